### src/keepalive_ping_monitor_defines.svh
// ----------------------------------------------------------------------------
// keepalive_ping_monitor_defines
// Assertion macros used by the keepalive monitor core RTL.
// ----------------------------------------------------------------------------
`ifndef KEEPALIVE_PING_MONITOR_DEFINES_SVH
`define KEEPALIVE_PING_MONITOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define KPM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keepalive monitor check failed");

// next-cycle implication, clocked on clk, off during reset
`define KPM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keepalive monitor check failed");

`endif

### src/kpm_pkg.sv
// ----------------------------------------------------------------------------
// kpm_pkg
// Types, codes and reset values of the keepalive ping monitor.
// ----------------------------------------------------------------------------
package kpm_pkg;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 32;

    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_CHECK = 3'd1,
        REQ_MSG   = 3'd2,
        REQ_START = 3'd3,
        REQ_STOP  = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_PING = 2'd1,
        ACT_PONG = 2'd2,
        ACT_DEAD = 2'd3
    } action_t;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_INTERVAL = 3'd0,
        CFG_MAX_MISS = 3'd1,
        CFG_PROGRAM  = 3'd2,
        CFG_VERSION  = 3'd3,
        CFG_PLAIN    = 3'd4,
        CFG_PING     = 3'd5,
        CFG_PONG     = 3'd6
    } cfg_reg_t;

    localparam logic [15:0] IntervalRst = 16'd5;
    localparam logic [7:0]  MaxMissRst  = 8'd5;
    localparam logic [31:0] ProgramRst  = 32'd0;
    localparam logic [31:0] VersionRst  = 32'd1;
    localparam logic [7:0]  PlainRst    = 8'd0;
    localparam logic [31:0] PingRst     = 32'd1;
    localparam logic [31:0] PongRst     = 32'd2;
    localparam logic [15:0] SecMax      = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] hdr_program;
        logic [31:0] hdr_version;
        logic [7:0]  hdr_kind;
        logic [31:0] hdr_procedure;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        is_keepalive;
        logic        remaining_valid;
        logic [15:0] remaining_seconds;
    } out_item_t;

    typedef struct packed {
        logic [15:0] interval_seconds;
        logic [7:0]  max_unanswered;
        logic [31:0] program_id;
        logic [31:0] protocol_version;
        logic [7:0]  plain_message_type;
        logic [31:0] ping_code;
        logic [31:0] pong_code;
        logic        budget_load;
    } cfg_bus_t;

endpackage

### src/kpm_cfg.sv
// ----------------------------------------------------------------------------
// kpm_cfg
// Configuration register file; flags writes of the miss budget.
// ----------------------------------------------------------------------------
module kpm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kpm_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [kpm_pkg::CfgDataW-1:0]  cfg_data,
    output kpm_pkg::cfg_bus_t             cfg
);

    logic [15:0] interval_reg;
    logic [7:0]  max_miss_reg;
    logic [31:0] program_reg;
    logic [31:0] version_reg;
    logic [7:0]  plain_reg;
    logic [31:0] ping_reg;
    logic [31:0] pong_reg;
    logic        budget_load_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg    <= kpm_pkg::IntervalRst;
            max_miss_reg    <= kpm_pkg::MaxMissRst;
            program_reg     <= kpm_pkg::ProgramRst;
            version_reg     <= kpm_pkg::VersionRst;
            plain_reg       <= kpm_pkg::PlainRst;
            ping_reg        <= kpm_pkg::PingRst;
            pong_reg        <= kpm_pkg::PongRst;
            budget_load_reg <= 1'b0;
        end
        else
        begin
            budget_load_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    kpm_pkg::CFG_INTERVAL: interval_reg <= cfg_data[15:0];
                    kpm_pkg::CFG_MAX_MISS:
                    begin
                        max_miss_reg    <= cfg_data[7:0];
                        budget_load_reg <= 1'b1;
                    end
                    kpm_pkg::CFG_PROGRAM: program_reg <= cfg_data;
                    kpm_pkg::CFG_VERSION: version_reg <= cfg_data;
                    kpm_pkg::CFG_PLAIN:   plain_reg   <= cfg_data[7:0];
                    kpm_pkg::CFG_PING:    ping_reg    <= cfg_data;
                    kpm_pkg::CFG_PONG:    pong_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.interval_seconds   = interval_reg;
        cfg.max_unanswered     = max_miss_reg;
        cfg.program_id         = program_reg;
        cfg.protocol_version   = version_reg;
        cfg.plain_message_type = plain_reg;
        cfg.ping_code          = ping_reg;
        cfg.pong_code          = pong_reg;
        cfg.budget_load        = budget_load_reg;
    end

endmodule

### src/kpm_in_stage.sv
// ----------------------------------------------------------------------------
// kpm_in_stage
// Input register: captures one event per cycle and holds it under stall.
// ----------------------------------------------------------------------------
module kpm_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  kpm_pkg::in_item_t in_data,
    output logic              item_valid,
    input  logic              item_stall,
    output kpm_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    kpm_pkg::in_item_t item_reg;
    logic              accept;

    assign in_stall = valid_reg && item_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (!item_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### src/kpm_core.sv
// ----------------------------------------------------------------------------
// kpm_core
// Watchdog state, per-event update and the result register.
// ----------------------------------------------------------------------------
`include "keepalive_ping_monitor_defines.svh"

module kpm_core (
    input  logic               clk,
    input  logic               rst_n,
    input  kpm_pkg::cfg_bus_t  cfg,
    input  logic               item_valid,
    output logic               item_stall,
    input  kpm_pkg::in_item_t  item,
    output logic               out_valid,
    input  logic               out_stall,
    output kpm_pkg::out_item_t out_data
);

    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] idle_reg, idle_next;
    logic [7:0]  tries_reg, tries_next;
    logic        armed_reg, armed_next;
    logic        running_reg, running_next;
    logic        valid_reg, valid_next;
    kpm_pkg::out_item_t result_reg, result_next;

    logic        load;
    logic [15:0] el_base;
    logic        expired;
    logic        do_eval;
    logic        hdr_match;
    logic [1:0]  action;

    assign item_stall = valid_reg && out_stall;
    assign load       = item_valid && !item_stall;

    always_comb
    begin
        elapsed_next = elapsed_reg;
        idle_next    = idle_reg;
        tries_next   = tries_reg;
        armed_next   = armed_reg;
        running_next = running_reg;
        action       = kpm_pkg::ACT_NONE;
        do_eval      = 1'b0;
        el_base      = elapsed_reg;
        hdr_match    = (item.hdr_program == cfg.program_id)
                    && (item.hdr_version == cfg.protocol_version)
                    && (item.hdr_kind == cfg.plain_message_type);

        case (item.req_type)
            kpm_pkg::REQ_TICK:
            begin
                if (idle_reg != kpm_pkg::SecMax)
                    idle_next = idle_reg + 16'd1;
                if (armed_reg && elapsed_reg != kpm_pkg::SecMax)
                    el_base = elapsed_reg + 16'd1;
                elapsed_next = el_base;
                do_eval      = running_reg;
            end
            kpm_pkg::REQ_CHECK: do_eval = 1'b1;
            kpm_pkg::REQ_MSG:
            begin
                tries_next   = cfg.max_unanswered;
                idle_next    = '0;
                elapsed_next = '0;
                armed_next   = 1'b1;
                if (hdr_match && item.hdr_procedure == cfg.ping_code)
                    action = kpm_pkg::ACT_PONG;
            end
            kpm_pkg::REQ_START:
            begin
                if (!running_reg && cfg.interval_seconds != '0)
                begin
                    elapsed_next = (idle_reg < cfg.interval_seconds) ?
                                   idle_reg : cfg.interval_seconds;
                    armed_next   = 1'b1;
                    running_next = 1'b1;
                end
            end
            kpm_pkg::REQ_STOP: running_next = 1'b0;
            default: ;
        endcase

        expired = do_eval && armed_reg && cfg.interval_seconds != '0
               && el_base >= cfg.interval_seconds;
        if (expired)
        begin
            if (tries_reg == '0)
                action = kpm_pkg::ACT_DEAD;
            else
            begin
                action       = kpm_pkg::ACT_PING;
                tries_next   = tries_reg - 8'd1;
                elapsed_next = '0;
            end
        end

        result_next.action            = action;
        result_next.is_keepalive      = (item.req_type == kpm_pkg::REQ_MSG) && hdr_match;
        result_next.remaining_valid   = armed_next && cfg.interval_seconds != '0;
        result_next.remaining_seconds = '0;
        if (result_next.remaining_valid && elapsed_next < cfg.interval_seconds)
            result_next.remaining_seconds = cfg.interval_seconds - elapsed_next;

        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            idle_reg    <= kpm_pkg::SecMax;
            tries_reg   <= kpm_pkg::MaxMissRst;
            armed_reg   <= 1'b0;
            running_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                elapsed_reg <= elapsed_next;
                idle_reg    <= idle_next;
                tries_reg   <= tries_next;
                armed_reg   <= armed_next;
                running_reg <= running_next;
            end
            else if (cfg.budget_load)
            begin
                // a budget write refills the miss count when no event loads
                tries_reg <= cfg.max_unanswered;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = result_reg;

    `KPM_ASSERT_IMP(a_run_armed, running_reg, armed_reg)
    `KPM_ASSERT_IMP(a_budget_cap, !cfg.budget_load, tries_reg <= cfg.max_unanswered)
    `KPM_ASSERT_NXT(a_ping_clears, load && action == kpm_pkg::ACT_PING, elapsed_reg == '0)
    `KPM_ASSERT_IMP(a_remain_valid, valid_reg && result_reg.remaining_seconds != '0,
                    result_reg.remaining_valid)

endmodule

### src/keepalive_ping_monitor.sv
// ----------------------------------------------------------------------------
// keepalive_ping_monitor
// Event-driven keepalive watchdog with ping, pong and miss budget.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one event per transfer (tick, check, message header,
//                 start, stop), in_valid / in_stall.
//   out channel : exactly one result per event, in order, out_valid /
//                 out_stall: action, keepalive flag and seconds remaining.
//   cfg channel : register writes by index, cfg_valid / cfg_ready; ready
//                 is always high. Write only while no event is in flight.
// An event passes through the input register, then through the update logic
// into the result register. Throughput is one event per cycle while
// out_stall is low, set by the state update between those two
// registers.
// Reset clears both stages, loads the register defaults and puts the
// watchdog disarmed with the idle counter saturated.
// When out_stall holds the result, the input register still takes one more
// event; after that in_stall rises until the result moves.
// ----------------------------------------------------------------------------
module keepalive_ping_monitor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  kpm_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output kpm_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kpm_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [kpm_pkg::CfgDataW-1:0]  cfg_data
);

    kpm_pkg::cfg_bus_t cfg;
    kpm_pkg::in_item_t item;
    logic              item_valid;
    logic              item_stall;

    kpm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kpm_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item)
    );

    kpm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

### verif/keepalive_ping_monitor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keepalive_ping_monitor_test
// Self-checking bench for the keepalive watchdog. A directed table covers the
// reset state, the expiry, ping, pong and dead paths and the request codes.
// Random phases follow under several register settings, then a short run of
// ticks with the watchdog stopped. Every result is checked against an
// in-bench model of the watchdog or, for the directed rows, against the
// table, with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module keepalive_ping_monitor_test;

    localparam int         LimitCycles = 3000000;
    localparam int         HoldCycles  = 300;
    localparam int         HoldAfter   = 400;
    localparam int         NumPhases   = 8;
    localparam int         PhaseEvents = 125;
    localparam int         SoakTicks   = 40;
    localparam int         TailCycles  = 10;
    localparam logic [2:0] ReqUndefLo  = 3'd5;
    localparam logic [2:0] ReqUndefHi  = 3'd7;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    kpm_pkg::in_item_t             in_data;
    logic                          out_valid;
    logic                          out_stall;
    kpm_pkg::out_item_t            out_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [kpm_pkg::CfgIndexW-1:0] cfg_index;
    logic [kpm_pkg::CfgDataW-1:0]  cfg_data;

    keepalive_ping_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watchdog copy: registers
    logic [15:0] wd_interval;
    logic [7:0]  wd_budget;
    logic [31:0] wd_program;
    logic [31:0] wd_version;
    logic [7:0]  wd_plain;
    logic [31:0] wd_ping;
    logic [31:0] wd_pong;
    // watchdog copy: state
    logic [15:0] wd_elapsed;
    logic [15:0] wd_idle;
    logic [7:0]  wd_tries;
    logic        wd_armed;
    logic        wd_running;

    kpm_pkg::out_item_t pending_results[$];

    typedef struct {
        logic               is_write;
        kpm_pkg::cfg_reg_t  reg_sel;
        logic [31:0]        wdata;
        kpm_pkg::in_item_t  ev;
        logic               typed;
        kpm_pkg::out_item_t want;
    } plan_row_t;

    plan_row_t plan[$];

    int errors;
    int events_sent;
    int results_seen;
    int pings_seen;
    int pongs_seen;
    int dead_seen;
    int keepalive_seen;

    bit in_up;
    bit cfg_up;
    bit gaps_on;
    int burst_left;

    function automatic void load_reset_state();
        wd_interval = kpm_pkg::IntervalRst;
        wd_budget   = kpm_pkg::MaxMissRst;
        wd_program  = kpm_pkg::ProgramRst;
        wd_version  = kpm_pkg::VersionRst;
        wd_plain    = kpm_pkg::PlainRst;
        wd_ping     = kpm_pkg::PingRst;
        wd_pong     = kpm_pkg::PongRst;
        wd_elapsed  = '0;
        wd_idle     = kpm_pkg::SecMax;
        wd_tries    = kpm_pkg::MaxMissRst;
        wd_armed    = 1'b0;
        wd_running  = 1'b0;
    endfunction

    function automatic void apply_write(kpm_pkg::cfg_reg_t sel, logic [31:0] val);
        case (sel)
            kpm_pkg::CFG_INTERVAL: wd_interval = val[15:0];
            kpm_pkg::CFG_MAX_MISS:
            begin
                wd_budget = val[7:0];
                wd_tries  = val[7:0];
            end
            kpm_pkg::CFG_PROGRAM:  wd_program = val;
            kpm_pkg::CFG_VERSION:  wd_version = val;
            kpm_pkg::CFG_PLAIN:    wd_plain   = val[7:0];
            kpm_pkg::CFG_PING:     wd_ping    = val;
            kpm_pkg::CFG_PONG:     wd_pong    = val;
            default: ;
        endcase
    endfunction

    function automatic kpm_pkg::action_t expire_check();
        if (wd_interval == 16'd0 || !wd_armed || wd_elapsed < wd_interval)
            return kpm_pkg::ACT_NONE;
        // budget spent: keep reporting dead until a message or budget write arrives
        if (wd_tries == 8'd0)
            return kpm_pkg::ACT_DEAD;
        wd_tries   = wd_tries - 8'd1;
        wd_elapsed = '0;
        return kpm_pkg::ACT_PING;
    endfunction

    function automatic kpm_pkg::out_item_t predict_result(kpm_pkg::in_item_t ev);
        kpm_pkg::out_item_t r;
        r = '0;
        case (ev.req_type)
            kpm_pkg::REQ_TICK:
            begin
                if (wd_idle != kpm_pkg::SecMax)
                    wd_idle = wd_idle + 16'd1;
                if (wd_armed && wd_elapsed != kpm_pkg::SecMax)
                    wd_elapsed = wd_elapsed + 16'd1;
                if (wd_running)
                    r.action = expire_check();
            end
            kpm_pkg::REQ_CHECK: r.action = expire_check();
            kpm_pkg::REQ_MSG:
            begin
                wd_tries   = wd_budget;
                wd_idle    = '0;
                wd_elapsed = '0;
                wd_armed   = 1'b1;
                if (ev.hdr_program == wd_program && ev.hdr_version == wd_version &&
                    ev.hdr_kind == wd_plain)
                begin
                    r.is_keepalive = 1'b1;
                    // ping test wins when ping and pong codes coincide
                    if (ev.hdr_procedure == wd_ping)
                        r.action = kpm_pkg::ACT_PONG;
                end
            end
            kpm_pkg::REQ_START:
            begin
                if (!wd_running && wd_interval != 16'd0)
                begin
                    wd_elapsed = (wd_idle < wd_interval) ? wd_idle : wd_interval;
                    wd_armed   = 1'b1;
                    wd_running = 1'b1;
                end
            end
            kpm_pkg::REQ_STOP: wd_running = 1'b0;
            default: ;
        endcase
        r.remaining_valid = wd_armed && (wd_interval != 16'd0);
        if (r.remaining_valid && wd_elapsed < wd_interval)
            r.remaining_seconds = wd_interval - wd_elapsed;
        return r;
    endfunction

    function automatic kpm_pkg::in_item_t random_event();
        kpm_pkg::in_item_t ev;
        int unsigned       pick;
        int unsigned       flavor;
        ev.hdr_program   = $urandom();
        ev.hdr_version   = $urandom();
        ev.hdr_kind      = 8'($urandom());
        ev.hdr_procedure = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 45)
            ev.req_type = kpm_pkg::REQ_TICK;
        else if (pick < 55)
            ev.req_type = kpm_pkg::REQ_CHECK;
        else if (pick < 77)
            ev.req_type = kpm_pkg::REQ_MSG;
        else if (pick < 87)
            ev.req_type = kpm_pkg::REQ_START;
        else if (pick < 97)
            ev.req_type = kpm_pkg::REQ_STOP;
        else
            ev.req_type = 3'($urandom_range(ReqUndefLo, ReqUndefHi));
        if (ev.req_type == kpm_pkg::REQ_MSG)
        begin
            // mostly keepalive headers, some with one field broken, some noise
            flavor = $urandom_range(0, 9);
            if (flavor < 8)
            begin
                ev.hdr_program = wd_program;
                ev.hdr_version = wd_version;
                ev.hdr_kind    = wd_plain;
            end
            if (flavor < 3)
                ev.hdr_procedure = wd_ping;
            else if (flavor < 5)
                ev.hdr_procedure = wd_pong;
            else if (flavor == 6 || flavor == 7)
            begin
                case ($urandom_range(0, 2))
                    0: ev.hdr_program = ev.hdr_program ^ (32'd1 << $urandom_range(0, 31));
                    1: ev.hdr_version = ev.hdr_version ^ (32'd1 << $urandom_range(0, 31));
                    default: ev.hdr_kind = ev.hdr_kind ^ (8'd1 << $urandom_range(0, 7));
                endcase
            end
        end
        return ev;
    endfunction

    function automatic plan_row_t event_row(logic [2:0] req, logic [31:0] prog,
                                            logic [31:0] vers, logic [7:0] kind,
                                            logic [31:0] proc, logic typed,
                                            kpm_pkg::action_t act, logic ka, logic rv,
                                            logic [15:0] rem);
        plan_row_t row;
        row.is_write               = 1'b0;
        row.reg_sel                = kpm_pkg::CFG_INTERVAL;
        row.wdata                  = '0;
        row.ev.req_type            = req;
        row.ev.hdr_program         = prog;
        row.ev.hdr_version         = vers;
        row.ev.hdr_kind            = kind;
        row.ev.hdr_procedure       = proc;
        row.typed                  = typed;
        row.want.action            = act;
        row.want.is_keepalive      = ka;
        row.want.remaining_valid   = rv;
        row.want.remaining_seconds = rem;
        return row;
    endfunction

    function automatic plan_row_t write_row(kpm_pkg::cfg_reg_t sel, logic [31:0] val);
        plan_row_t row;
        row          = event_row(kpm_pkg::REQ_TICK, '0, '0, '0, '0, 1'b0,
                                 kpm_pkg::ACT_NONE, 1'b0, 1'b0, '0);
        row.is_write = 1'b1;
        row.reg_sel  = sel;
        row.wdata    = val;
        return row;
    endfunction

    task automatic send_event(input kpm_pkg::in_item_t ev, input logic typed,
                              input kpm_pkg::out_item_t want);
        int                 gap;
        kpm_pkg::out_item_t guess;
        if (cfg_up)
        begin
            cfg_valid <= 1'b0;
            cfg_up = 1'b0;
        end
        if (gaps_on && burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                if (in_up)
                begin
                    in_valid <= 1'b0;
                    in_up = 1'b0;
                end
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_up = 1'b1;
        in_data <= ev;
        do
            @(posedge clk);
        while (in_stall);
        guess = predict_result(ev);
        pending_results.push_back(typed ? want : guess);
        events_sent++;
    endtask

    task automatic drain_results();
        if (in_up)
        begin
            in_valid <= 1'b0;
            in_up = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input kpm_pkg::cfg_reg_t sel, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_up = 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_write(sel, val);
    endtask

    task automatic program_phase(input int p);
        logic [31:0] noise;
        logic [15:0] iv;
        logic [7:0]  bud;
        logic [7:0]  plain;
        logic [31:0] prog;
        logic [31:0] vers;
        logic [31:0] ping;
        logic [31:0] pong;
        noise = $urandom();
        case (p)
            0: iv = 16'd1;
            1: iv = 16'd0;
            2: iv = kpm_pkg::SecMax;
            default: iv = 16'($urandom_range(2, 8));
        endcase
        case (p)
            0: bud = 8'd0;
            1: bud = 8'hFF;
            2: bud = 8'd1;
            default: bud = 8'($urandom_range(0, 4));
        endcase
        prog  = (p % 3 == 0) ? 32'd0 : (p % 3 == 1) ? '1 : $urandom();
        vers  = (p % 3 == 1) ? 32'd0 : (p % 3 == 2) ? '1 : $urandom();
        plain = (p == 0) ? 8'd0 : (p == 1) ? 8'hFF : 8'($urandom());
        ping  = (p == 1) ? '1 : $urandom();
        pong  = (p == 1) ? 32'd0 : $urandom();
        // equal codes: ping must take precedence
        if (p == 3)
            pong = ping;
        write_reg(kpm_pkg::CFG_INTERVAL, {noise[31:16], iv});
        write_reg(kpm_pkg::CFG_PROGRAM, prog);
        write_reg(kpm_pkg::CFG_VERSION, vers);
        write_reg(kpm_pkg::CFG_PLAIN, {noise[31:8], plain});
        write_reg(kpm_pkg::CFG_PING, ping);
        write_reg(kpm_pkg::CFG_PONG, pong);
        write_reg(kpm_pkg::CFG_MAX_MISS, {noise[31:8], bud});
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : stimulus
        kpm_pkg::in_item_t ev;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        in_up      = 1'b0;
        cfg_up     = 1'b0;
        gaps_on    = 1'b1;
        burst_left = 0;
        load_reset_state();

        // reset registers: interval 5, budget 5, header 0/1/0, ping 1, pong 2
        plan.push_back(event_row(kpm_pkg::REQ_TICK, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b0, 16'd0));
        plan.push_back(event_row(kpm_pkg::REQ_CHECK, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b0, 16'd0));
        plan.push_back(event_row(kpm_pkg::REQ_START, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b1, 16'd0));
        plan.push_back(event_row(kpm_pkg::REQ_TICK, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_PING, 1'b0, 1'b1, 16'd5));
        plan.push_back(event_row(kpm_pkg::REQ_START, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b1, 16'd5));
        plan.push_back(event_row(kpm_pkg::REQ_STOP, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b1, 16'd5));
        plan.push_back(event_row(kpm_pkg::REQ_TICK, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b1, 16'd4));
        plan.push_back(event_row(kpm_pkg::REQ_MSG, kpm_pkg::ProgramRst, kpm_pkg::VersionRst,
                                 kpm_pkg::PlainRst, kpm_pkg::PingRst,
                                 1'b1, kpm_pkg::ACT_PONG, 1'b1, 1'b1, 16'd5));
        plan.push_back(event_row(kpm_pkg::REQ_MSG, kpm_pkg::ProgramRst, kpm_pkg::VersionRst,
                                 kpm_pkg::PlainRst, kpm_pkg::PongRst,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b1, 1'b1, 16'd5));
        plan.push_back(event_row(kpm_pkg::REQ_MSG, '1, '1, '1, '1,
                                 1'b0, kpm_pkg::ACT_NONE, 1'b0, 1'b0, 16'd0));
        plan.push_back(event_row(kpm_pkg::REQ_MSG, kpm_pkg::ProgramRst, kpm_pkg::VersionRst,
                                 '1, kpm_pkg::PingRst,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b1, 16'd5));
        plan.push_back(event_row(ReqUndefHi, '1, '1, '1, '1,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b1, 16'd5));
        plan.push_back(write_row(kpm_pkg::CFG_MAX_MISS, 32'd0));
        plan.push_back(write_row(kpm_pkg::CFG_INTERVAL, 32'd1));
        plan.push_back(event_row(kpm_pkg::REQ_TICK, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b1, 16'd0));
        plan.push_back(event_row(kpm_pkg::REQ_CHECK, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_DEAD, 1'b0, 1'b1, 16'd0));
        plan.push_back(event_row(kpm_pkg::REQ_CHECK, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_DEAD, 1'b0, 1'b1, 16'd0));
        plan.push_back(event_row(kpm_pkg::REQ_MSG, kpm_pkg::ProgramRst, kpm_pkg::VersionRst,
                                 kpm_pkg::PlainRst, kpm_pkg::PingRst,
                                 1'b1, kpm_pkg::ACT_PONG, 1'b1, 1'b1, 16'd1));
        plan.push_back(write_row(kpm_pkg::CFG_INTERVAL, 32'h0000_FFFF));
        plan.push_back(event_row(kpm_pkg::REQ_START, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b1, kpm_pkg::SecMax));
        plan.push_back(event_row(kpm_pkg::REQ_TICK, '0, '0, '0, '0,
                                 1'b0, kpm_pkg::ACT_NONE, 1'b0, 1'b0, 16'd0));
        plan.push_back(write_row(kpm_pkg::CFG_INTERVAL, 32'd0));
        plan.push_back(event_row(kpm_pkg::REQ_TICK, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b0, 16'd0));
        plan.push_back(event_row(kpm_pkg::REQ_STOP, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b0, 16'd0));
        plan.push_back(event_row(kpm_pkg::REQ_START, '0, '0, '0, '0,
                                 1'b1, kpm_pkg::ACT_NONE, 1'b0, 1'b0, 16'd0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                drain_results();
                write_reg(plan[i].reg_sel, plan[i].wdata);
            end
            else
                send_event(plan[i].ev, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < NumPhases; p++)
        begin
            drain_results();
            program_phase(p);
            repeat (PhaseEvents)
                send_event(random_event(), 1'b0, '0);
        end

        // arm, stop, then tick with the watchdog halted
        drain_results();
        write_reg(kpm_pkg::CFG_INTERVAL, 32'h0000_FFFF);
        write_reg(kpm_pkg::CFG_MAX_MISS, 32'd2);
        gaps_on = 1'b0;
        ev = random_event();
        ev.req_type = kpm_pkg::REQ_MSG;
        send_event(ev, 1'b0, '0);
        ev.req_type = kpm_pkg::REQ_STOP;
        send_event(ev, 1'b0, '0);
        ev.req_type = kpm_pkg::REQ_TICK;
        repeat (SoakTicks)
            send_event(ev, 1'b0, '0);
        ev.req_type = kpm_pkg::REQ_CHECK;
        send_event(ev, 1'b0, '0);
        ev.req_type = kpm_pkg::REQ_START;
        send_event(ev, 1'b0, '0);
        ev.req_type = kpm_pkg::REQ_TICK;
        send_event(ev, 1'b0, '0);
        send_event(ev, 1'b0, '0);

        drain_results();
        repeat (TailCycles) @(posedge clk);
        $display("Checked %0d events: directed table, %0d random register settings, %0d-tick run",
                 events_sent, NumPhases, SoakTicks);
        $display("Saw %0d pings, %0d pongs, %0d dead reports, %0d keepalive headers",
                 pings_seen, pongs_seen, dead_seen, keepalive_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : result_sink
        int mode;
        int stretch;
        int burst;
        int beat;
        bit held;
        held  = 1'b0;
        burst = 0;
        beat  = 0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            repeat (stretch)
            begin
                // one long hold-off so the block fills and stalls its input
                if (!held && results_seen >= HoldAfter)
                begin
                    held = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HoldCycles) @(posedge clk);
                end
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 2) == 0);
                    2: out_stall <= (beat % 4 == 3);
                    default:
                    begin
                        if (burst == 0 && $urandom_range(0, 7) == 0)
                            burst = $urandom_range(1, 5);
                        out_stall <= (burst > 0);
                        if (burst > 0)
                            burst--;
                    end
                endcase
                beat++;
                @(posedge clk);
            end
        end
    end

    initial
    begin : result_check
        kpm_pkg::out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                results_seen++;
                case (out_data.action)
                    kpm_pkg::ACT_PING: pings_seen++;
                    kpm_pkg::ACT_PONG: pongs_seen++;
                    kpm_pkg::ACT_DEAD: dead_seen++;
                    default: ;
                endcase
                if (out_data.is_keepalive === 1'b1)
                    keepalive_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing pending: action %0d", out_data.action);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.action !== want.action)
                    begin
                        $error("action: expected %0d, got %0d", want.action, out_data.action);
                        errors++;
                    end
                    if (out_data.is_keepalive !== want.is_keepalive)
                    begin
                        $error("is_keepalive: expected %0d, got %0d",
                               want.is_keepalive, out_data.is_keepalive);
                        errors++;
                    end
                    if (out_data.remaining_valid !== want.remaining_valid)
                    begin
                        $error("remaining_valid: expected %0d, got %0d",
                               want.remaining_valid, out_data.remaining_valid);
                        errors++;
                    end
                    if (out_data.remaining_seconds !== want.remaining_seconds)
                    begin
                        $error("remaining_seconds: expected %0d, got %0d",
                               want.remaining_seconds, out_data.remaining_seconds);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin : cycle_limit
        repeat (LimitCycles) @(posedge clk);
        $display("no completion within %0d cycles, %0d results outstanding",
                 LimitCycles, pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
